@@ rtl/mtu_pkg.sv @@
`timescale 1ns / 1ps

package mtu_pkg;

    // Matrix geometry and element format
    localparam int DIM    = 4;
    localparam int Q_W    = 32;
    localparam int COL_W  = $clog2(DIM);
    localparam int WORD_W = DIM * Q_W;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Command codes
    localparam logic [2:0] CMD_WRITE_A = 3'd0;
    localparam logic [2:0] CMD_WRITE_B = 3'd1;
    localparam logic [2:0] CMD_ADD     = 3'd2;
    localparam logic [2:0] CMD_SUB     = 3'd3;
    localparam logic [2:0] CMD_MUL     = 3'd4;
    localparam logic [2:0] CMD_READ_A  = 3'd5;
    localparam logic [2:0] CMD_XFORM   = 3'd6;

    // Result kinds
    localparam logic KIND_VECTOR  = 1'b0;
    localparam logic KIND_ELEMENT = 1'b1;

    typedef logic signed [Q_W-1:0] q_t;
    typedef logic [WORD_W-1:0]     word_t;

    // Clamp a 33-bit sum or difference to the element range
    function automatic q_t sat33(input logic signed [Q_W:0] v);
        q_t res;
        if (v[Q_W] == v[Q_W-1]) begin
            res = v[Q_W-1:0];
        end else if (v[Q_W]) begin
            res = Q_MIN;
        end else begin
            res = Q_MAX;
        end
        return res;
    endfunction

endpackage

@@ rtl/matrix4_transform_unit.sv @@
`timescale 1ns / 1ps
// 4x4 matrix transform unit, signed fixed point with FRAC_BITS fraction bits.
// Input channel (s_*): one command transaction per item; write an element of
// A or B, replace A with A+B, A-B or A*B, read an element of A, or transform
// the vector (s_vec_x..s_vec_w) by A. Result channel (m_*): one transaction
// for each read (m_kind = 1, element on m_out_x, other lanes zero) and each
// transform (m_kind = 0, four results). Other commands give no result.
// Matrices live column-wise in two synchronous memories (one column per word,
// A in two banks so A*B never overwrites columns it still reads).
// s_ready is high only while idle, so each command finishes, or for a read
// or transform loads its result, before the next is accepted. The multiply
// walks sixteen column reads through four lane multipliers and a
// three-stage read/multiply/accumulate pipeline; the memory read port sets
// one column per cycle.
// Results sit in an output register; a stalled receiver holds a read or
// transform in its final state, while writes and matrix operations still go.
// Reset clears both matrices with a clearing pass over their columns;
// s_ready stays low until it ends.
module matrix4_transform_unit
    import mtu_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_command,
    input  logic [3:0]            s_index,
    input  logic signed [Q_W-1:0] s_value,
    input  logic signed [Q_W-1:0] s_vec_x,
    input  logic signed [Q_W-1:0] s_vec_y,
    input  logic signed [Q_W-1:0] s_vec_z,
    input  logic signed [Q_W-1:0] s_vec_w,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_kind,
    output logic signed [Q_W-1:0] m_out_x,
    output logic signed [Q_W-1:0] m_out_y,
    output logic signed [Q_W-1:0] m_out_z,
    output logic signed [Q_W-1:0] m_out_w
);

    localparam int SHF_W = 2 * Q_W - FRAC_BITS;
    localparam int ACC_W = SHF_W + 2;
    localparam int AA_W  = COL_W + 1;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    // Control state
    state_t            state_reg, state_next;
    logic [COL_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              bank_reg, bank_next;
    logic              issue_reg, issue_next;
    logic [3:0]        step_reg, step_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic              p1_valid_reg, p1_valid_next;
    logic              p2_valid_reg, p2_valid_next;
    logic              p3_valid_reg, p3_valid_next;
    logic              m_valid_reg, m_valid_next;

    // Payload registers
    logic [COL_W-1:0]  idx_lane_reg;
    q_t                vec_reg [DIM];
    logic              p1_first_reg, p1_last_reg, p1_fin_reg;
    logic [COL_W-1:0]  p1_lane_reg, p1_col_reg;
    logic              p2_first_reg, p2_last_reg, p2_fin_reg;
    logic [COL_W-1:0]  p2_col_reg;
    logic              p3_last_reg, p3_fin_reg;
    logic [COL_W-1:0]  p3_col_reg;
    logic signed [2*Q_W-1:0] prod_reg [DIM];
    logic signed [ACC_W-1:0] acc_reg [DIM];
    logic              kind_reg;
    q_t                out_reg [DIM];

    // Memories
    word_t             mem_a [2*DIM];
    word_t             mem_b [DIM];
    word_t             rdata_a_reg, rdata_b_reg;
    logic              rd_a_en, rd_b_en;
    logic [AA_W-1:0]   rd_a_addr;
    logic [COL_W-1:0]  rd_b_addr;
    logic              wr_a_en, wr_b_en;
    logic [AA_W-1:0]   wr_a_addr;
    logic [COL_W-1:0]  wr_b_addr;
    logic [DIM-1:0]    wr_a_mask, wr_b_mask;
    word_t             wr_a_data, wr_b_data;

    // Datapath helpers
    logic              accept;
    logic              out_free;
    logic              mul_cmd;
    logic [3:0]        last_step;
    logic              issue_fin;
    q_t                a_lane [DIM];
    q_t                b_lane [DIM];
    q_t                sum_lane [DIM];
    q_t                acc_sat [DIM];
    q_t                op_b;
    word_t             sum_word, acc_word;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign mul_cmd  = (cmd_reg == CMD_MUL);
    assign last_step = mul_cmd ? 4'd15 : 4'd3;
    assign issue_fin = issue_reg && (step_reg == last_step);

    assign m_valid = m_valid_reg;
    assign m_kind  = kind_reg;
    assign m_out_x = out_reg[0];
    assign m_out_y = out_reg[1];
    assign m_out_z = out_reg[2];
    assign m_out_w = out_reg[3];

    // Unpack memory words into lanes; saturate sums and accumulators
    always_comb begin
        for (int l = 0; l < DIM; l++) begin
            a_lane[l] = rdata_a_reg[l*Q_W +: Q_W];
            b_lane[l] = rdata_b_reg[l*Q_W +: Q_W];
            if (cmd_reg == CMD_SUB) begin
                sum_lane[l] = sat33({a_lane[l][Q_W-1], a_lane[l]}
                                    - {b_lane[l][Q_W-1], b_lane[l]});
            end else begin
                sum_lane[l] = sat33({a_lane[l][Q_W-1], a_lane[l]}
                                    + {b_lane[l][Q_W-1], b_lane[l]});
            end
            if ((&acc_reg[l][ACC_W-1:Q_W-1]) || !(|acc_reg[l][ACC_W-1:Q_W-1])) begin
                acc_sat[l] = acc_reg[l][Q_W-1:0];
            end else if (acc_reg[l][ACC_W-1]) begin
                acc_sat[l] = Q_MIN;
            end else begin
                acc_sat[l] = Q_MAX;
            end
            sum_word[l*Q_W +: Q_W] = sum_lane[l];
            acc_word[l*Q_W +: Q_W] = acc_sat[l];
        end
        op_b = mul_cmd ? b_lane[p1_lane_reg] : vec_reg[p1_lane_reg];
    end

    // Sequence commands: memory ports, pipeline tags and state
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        bank_next     = bank_reg;
        issue_next    = issue_reg;
        step_next     = step_reg;
        cmd_next      = cmd_reg;
        p1_valid_next = 1'b0;
        p2_valid_next = p1_valid_reg && !(cmd_reg == CMD_ADD || cmd_reg == CMD_SUB);
        p3_valid_next = p2_valid_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        rd_a_en   = 1'b0;
        rd_a_addr = {bank_reg, step_reg[COL_W-1:0]};
        rd_b_en   = 1'b0;
        rd_b_addr = mul_cmd ? step_reg[2*COL_W-1:COL_W] : step_reg[COL_W-1:0];
        wr_a_en   = 1'b0;
        wr_a_addr = {bank_reg, s_index[3:2]};
        wr_a_mask = '0;
        wr_a_data = {DIM{s_value}};
        wr_b_en   = 1'b0;
        wr_b_addr = s_index[3:2];
        wr_b_mask = '0;
        wr_b_data = {DIM{s_value}};

        case (state_reg)
            ST_CLEAR: begin
                // Zero one column of A (bank 0) and B per cycle
                wr_a_en   = 1'b1;
                wr_a_addr = {1'b0, clr_cnt_reg};
                wr_a_mask = '1;
                wr_a_data = '0;
                wr_b_en   = 1'b1;
                wr_b_addr = clr_cnt_reg;
                wr_b_mask = '1;
                wr_b_data = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == COL_W'(DIM - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd_next  = s_command;
                    step_next = '0;
                    case (s_command)
                        CMD_WRITE_A: begin
                            wr_a_en   = 1'b1;
                            wr_a_mask = DIM'(1) << s_index[1:0];
                        end
                        CMD_WRITE_B: begin
                            wr_b_en   = 1'b1;
                            wr_b_mask = DIM'(1) << s_index[1:0];
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_XFORM: begin
                            issue_next = 1'b1;
                            state_next = ST_RUN;
                        end
                        CMD_READ_A: begin
                            rd_a_en    = 1'b1;
                            rd_a_addr  = {bank_reg, s_index[3:2]};
                            state_next = ST_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                // Issue one column read per cycle
                if (issue_reg) begin
                    rd_a_en       = 1'b1;
                    rd_b_en       = 1'b1;
                    p1_valid_next = 1'b1;
                    step_next     = step_reg + 1'b1;
                    if (issue_fin) begin
                        issue_next = 1'b0;
                    end
                end
                // Write back element-wise sums or differences
                if (p1_valid_reg && (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB)) begin
                    wr_a_en   = 1'b1;
                    wr_a_addr = {bank_reg, p1_col_reg};
                    wr_a_mask = '1;
                    wr_a_data = sum_word;
                    if (p1_fin_reg) begin
                        state_next = ST_IDLE;
                    end
                end
                // Finish a product column
                if (p3_valid_reg && p3_last_reg) begin
                    if (mul_cmd) begin
                        wr_a_en   = 1'b1;
                        wr_a_addr = {!bank_reg, p3_col_reg};
                        wr_a_mask = '1;
                        wr_a_data = acc_word;
                        if (p3_fin_reg) begin
                            bank_next  = !bank_reg;
                            state_next = ST_IDLE;
                        end
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            bank_reg     <= 1'b0;
            issue_reg    <= 1'b0;
            step_reg     <= '0;
            cmd_reg      <= CMD_WRITE_A;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            bank_reg     <= bank_next;
            issue_reg    <= issue_next;
            step_reg     <= step_next;
            cmd_reg      <= cmd_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            p3_valid_reg <= p3_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Matrix A memory: two banks of column words, lane write mask
    always_ff @(posedge aclk) begin
        for (int l = 0; l < DIM; l++) begin
            if (wr_a_en && wr_a_mask[l]) begin
                mem_a[wr_a_addr][l*Q_W +: Q_W] <= wr_a_data[l*Q_W +: Q_W];
            end
        end
        if (rd_a_en) begin
            rdata_a_reg <= mem_a[rd_a_addr];
        end
    end

    // Matrix B memory: column words, lane write mask
    always_ff @(posedge aclk) begin
        for (int l = 0; l < DIM; l++) begin
            if (wr_b_en && wr_b_mask[l]) begin
                mem_b[wr_b_addr][l*Q_W +: Q_W] <= wr_b_data[l*Q_W +: Q_W];
            end
        end
        if (rd_b_en) begin
            rdata_b_reg <= mem_b[rd_b_addr];
        end
    end

    // Pipeline payload: capture operands, multiply, accumulate
    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_lane_reg <= s_index[1:0];
            vec_reg[0]   <= s_vec_x;
            vec_reg[1]   <= s_vec_y;
            vec_reg[2]   <= s_vec_z;
            vec_reg[3]   <= s_vec_w;
        end
        p1_lane_reg  <= step_reg[COL_W-1:0];
        p1_col_reg   <= mul_cmd ? step_reg[2*COL_W-1:COL_W] : step_reg[COL_W-1:0];
        p1_first_reg <= (step_reg[COL_W-1:0] == '0);
        p1_last_reg  <= (step_reg[COL_W-1:0] == COL_W'(DIM - 1));
        p1_fin_reg   <= issue_fin;
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
        p2_fin_reg   <= p1_fin_reg;
        p2_col_reg   <= p1_col_reg;
        p3_last_reg  <= p2_last_reg;
        p3_fin_reg   <= p2_fin_reg;
        p3_col_reg   <= p2_col_reg;
        for (int l = 0; l < DIM; l++) begin
            if (p1_valid_reg) begin
                prod_reg[l] <= a_lane[l] * op_b;
            end
            if (p2_valid_reg) begin
                acc_reg[l] <= (p2_first_reg ? ACC_W'(0) : acc_reg[l])
                              + {{2{prod_reg[l][2*Q_W-1]}}, prod_reg[l][2*Q_W-1:FRAC_BITS]};
            end
        end
    end

    // Output register: load a read element or a transformed vector
    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            if (cmd_reg == CMD_READ_A) begin
                kind_reg <= KIND_ELEMENT;
                out_reg[0] <= a_lane[idx_lane_reg];
                for (int l = 1; l < DIM; l++) begin
                    out_reg[l] <= '0;
                end
            end else begin
                kind_reg <= KIND_VECTOR;
                for (int l = 0; l < DIM; l++) begin
                    out_reg[l] <= acc_sat[l];
                end
            end
        end
    end

endmodule
